### src/atfp_pkg.sv
`timescale 1ns / 1ps
package atfp_pkg;

  localparam int FRAME_BYTES = 256;
  localparam int MAX_POINTS  = 24;
  localparam int FRAC_BITS   = 16;

  localparam int LEN_W  = $clog2(FRAME_BYTES);
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int PT_W   = 5;   // point_index / point_count port width
  localparam int IP_W   = 33;  // integer part, saturates at 2^32
  localparam int FR_W   = 30;  // up to nine fraction digits
  localparam int FN_W   = 4;
  localparam int QW     = FRAC_BITS + 1;         // rounded quotient bits
  localparam int NW     = FR_W + FRAC_BITS + 1;  // dividend bits
  localparam int MW     = IP_W + FRAC_BITS + 1;  // magnitude bits
  localparam int DC_W   = $clog2(QW + 1);

  localparam logic [1:0] KIND_CENTER = 2'd0;
  localparam logic [1:0] KIND_BLOB   = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_P     = 8'h50;

  typedef struct packed {
    logic            neg;
    logic [IP_W-1:0] ip;
    logic [FR_W-1:0] fr;
    logic [FN_W-1:0] fn;
  } num_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CNT_W-1:0] count;
    num_t             x;
    num_t             y;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } pwr_t;

  function automatic logic [FR_W-1:0] pow10(input logic [FN_W-1:0] n);
    logic [FR_W-1:0] r;
    unique case (n)
      4'd0: r = FR_W'(1);
      4'd1: r = FR_W'(10);
      4'd2: r = FR_W'(100);
      4'd3: r = FR_W'(1000);
      4'd4: r = FR_W'(10000);
      4'd5: r = FR_W'(100000);
      4'd6: r = FR_W'(1000000);
      4'd7: r = FR_W'(10000000);
      4'd8: r = FR_W'(100000000);
      4'd9: r = FR_W'(1000000000);
      default: r = FR_W'(1);
    endcase
    return r;
  endfunction

endpackage

### src/atfp_queue.sv
`timescale 1ns / 1ps
module atfp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  atfp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output atfp_pkg::job_t head_job,
  output logic          empty
);
  import atfp_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign head_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule

### src/atfp_front.sv
`timescale 1ns / 1ps
module atfp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_rx_byte,
  input  logic [2:0]     kind_enable,
  input  logic           q_full,
  output logic           q_push,
  output atfp_pkg::job_t q_job,
  output atfp_pkg::pwr_t pt_wr,
  input  logic           list_done
);
  import atfp_pkg::*;

  typedef enum logic [3:0] {
    F_KIND, F_COLON, F_BRACK, F_NUM_PRE, F_NUM_INT, F_NUM_FRAC, F_PAIR_OK, F_FAIL,
    F_LIST_OPT, F_U_PRE, F_U_DIG, F_SKIP, F_LIST_END
  } fst_t;

  fst_t             st_r, st_nxt, st_eff;
  logic [1:0]       kind_r, kind_nxt;
  logic             second_r, second_nxt;
  logic             neg_r, neg_nxt, nd_r, nd_nxt;
  logic [IP_W-1:0]  ip_r, ip_nxt;
  logic [FR_W-1:0]  fr_r, fr_nxt;
  logic [FN_W-1:0]  fn_r, fn_nxt;
  num_t             x_r, x_nxt;
  logic [15:0]      uv_r, uv_nxt, px_r, px_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] len_r;
  logic             busy_r;

  logic        is_nl, accept, ovf, list_state, blank, digit, commit, job_ok;
  logic [7:0]  c;
  logic [3:0]  d;
  logic [IP_W+3:0] ip_mul;
  logic [15:0] uval;

  assign is_nl  = (in_rx_byte == CH_NL);
  assign c      = is_nl ? 8'd0 : in_rx_byte;
  assign d      = c[3:0];
  assign blank  = (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  assign digit  = (c >= 8'h30) && (c <= 8'h39);
  assign ovf    = !is_nl && (len_r == LEN_W'(FRAME_BYTES - 1));
  assign list_state = (st_r == F_LIST_OPT) || (st_r == F_U_PRE) || (st_r == F_U_DIG) ||
                      (st_r == F_SKIP) || (st_r == F_LIST_END);
  // hold list bytes while the back end still reads the point store
  assign in_stall = (is_nl && q_full) || (busy_r && list_state);
  assign accept   = in_valid && !in_stall;
  assign ip_mul   = ({4'd0, ip_r} << 3) + ({4'd0, ip_r} << 1) + (IP_W+4)'(d);
  assign uval     = neg_r ? (16'd0 - uv_r) : uv_r;

  always_comb begin
    st_nxt     = st_r;
    kind_nxt   = kind_r;
    second_nxt = second_r;
    neg_nxt    = neg_r;
    nd_nxt     = nd_r;
    ip_nxt     = ip_r;
    fr_nxt     = fr_r;
    fn_nxt     = fn_r;
    x_nxt      = x_r;
    uv_nxt     = uv_r;
    px_nxt     = px_r;
    cnt_nxt    = cnt_r;
    commit     = 1'b0;
    st_eff     = (st_r == F_LIST_OPT && c != CH_LBRK) ? F_U_PRE : st_r;
    unique case (st_eff)
      F_KIND: begin
        priority if (c == CH_C) begin
          kind_nxt = KIND_CENTER; st_nxt = F_COLON;
        end else if (c == CH_B) begin
          kind_nxt = KIND_BLOB; st_nxt = F_COLON;
        end else if (c == CH_P) begin
          kind_nxt = KIND_LIST; st_nxt = F_COLON;
        end else begin
          st_nxt = F_FAIL;
        end
      end
      F_COLON: begin
        neg_nxt = 1'b0; nd_nxt = 1'b0; uv_nxt = '0; second_nxt = 1'b0;
        if (c != CH_COLON) st_nxt = F_FAIL;
        else if (kind_r == KIND_LIST) st_nxt = F_LIST_OPT;
        else st_nxt = F_BRACK;
      end
      F_BRACK: begin
        ip_nxt = '0; fr_nxt = '0; fn_nxt = '0;
        st_nxt = (c == CH_LBRK) ? F_NUM_PRE : F_FAIL;
      end
      F_NUM_PRE, F_NUM_INT, F_NUM_FRAC: begin
        priority if (st_eff == F_NUM_PRE && blank) begin
          st_nxt = F_NUM_PRE;
        end else if (st_eff == F_NUM_PRE && (c == CH_PLUS || c == CH_MINUS)) begin
          neg_nxt = (c == CH_MINUS); st_nxt = F_NUM_INT;
        end else if (st_eff != F_NUM_FRAC && digit) begin
          ip_nxt = (ip_mul > (IP_W+4)'(34'h1_0000_0000)) ? IP_W'(34'h1_0000_0000)
                                                         : ip_mul[IP_W-1:0];
          nd_nxt = 1'b1; st_nxt = F_NUM_INT;
        end else if (st_eff != F_NUM_FRAC && c == CH_DOT) begin
          st_nxt = F_NUM_FRAC;
        end else if (st_eff == F_NUM_FRAC && digit) begin
          if (fn_r < FN_W'(9)) begin
            fr_nxt = (fr_r << 3) + (fr_r << 1) + FR_W'(d);
            fn_nxt = fn_r + FN_W'(1);
          end
          nd_nxt = 1'b1;
        end else if (st_eff == F_NUM_PRE || !nd_r) begin
          st_nxt = F_FAIL;
        end else if (second_r) begin
          st_nxt = F_PAIR_OK;
        end else if (c == CH_COMMA) begin
          x_nxt = '{neg: neg_r, ip: ip_r, fr: fr_r, fn: fn_r};
          ip_nxt = '0; fr_nxt = '0; fn_nxt = '0; neg_nxt = 1'b0; nd_nxt = 1'b0;
          second_nxt = 1'b1; st_nxt = F_NUM_PRE;
        end else begin
          st_nxt = F_FAIL;
        end
      end
      F_LIST_OPT: st_nxt = F_U_PRE;
      F_U_PRE: begin
        priority if (blank) begin
          st_nxt = F_U_PRE;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg_nxt = (c == CH_MINUS); st_nxt = F_U_DIG;
        end else if (digit) begin
          uv_nxt = 16'(d); nd_nxt = 1'b1; st_nxt = F_U_DIG;
        end else begin
          st_nxt = F_LIST_END;
        end
      end
      F_U_DIG: begin
        priority if (digit) begin
          uv_nxt = (uv_r << 3) + (uv_r << 1) + 16'(d); nd_nxt = 1'b1;
        end else if (!nd_r) begin
          st_nxt = F_LIST_END;
        end else if (!second_r) begin
          if (c == CH_COLON) begin
            px_nxt = uval; uv_nxt = '0; neg_nxt = 1'b0; nd_nxt = 1'b0;
            second_nxt = 1'b1; st_nxt = F_U_PRE;
          end else begin
            st_nxt = F_LIST_END;
          end
        end else begin
          commit  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          uv_nxt = '0; neg_nxt = 1'b0; nd_nxt = 1'b0; second_nxt = 1'b0;
          priority if (cnt_nxt == CNT_W'(MAX_POINTS)) st_nxt = F_LIST_END;
          else if (c == CH_COMMA) st_nxt = F_U_PRE;
          else if (c == 8'd0) st_nxt = F_LIST_END;
          else st_nxt = F_SKIP;
        end
      end
      F_SKIP: begin
        uv_nxt = '0; neg_nxt = 1'b0; nd_nxt = 1'b0; second_nxt = 1'b0;
        if (c == CH_COMMA) st_nxt = F_U_PRE;
        else if (c == 8'd0) st_nxt = F_LIST_END;
      end
      F_PAIR_OK, F_FAIL, F_LIST_END: st_nxt = st_r;
      default: st_nxt = F_FAIL;
    endcase
  end

  always_comb begin
    pt_wr.en   = accept && !ovf && commit;
    pt_wr.addr = cnt_r[ADDR_W-1:0];
    pt_wr.data = {uval, px_r};
    q_job.kind  = kind_r;
    q_job.count = cnt_nxt;
    q_job.x     = x_r;
    q_job.y     = '{neg: neg_r, ip: ip_r, fr: fr_r, fn: fn_r};
    if (kind_r == KIND_LIST) job_ok = (cnt_nxt != '0) && kind_enable[2];
    else job_ok = (st_nxt == F_PAIR_OK) && kind_enable[kind_r[0]];
    q_push = accept && is_nl && job_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= F_KIND;
      kind_r   <= KIND_CENTER;
      second_r <= 1'b0;
      cnt_r    <= '0;
      len_r    <= '0;
      busy_r   <= 1'b0;
      nd_r     <= 1'b0;
      neg_r    <= 1'b0;
    end else begin
      if (q_push && kind_r == KIND_LIST) busy_r <= 1'b1;
      else if (list_done) busy_r <= 1'b0;
      if (accept) begin
        if (is_nl || ovf) begin
          // newline or overrun: restart the frame, drop the overrun byte
          st_r     <= F_KIND;
          second_r <= 1'b0;
          cnt_r    <= '0;
          len_r    <= '0;
        end else begin
          st_r     <= st_nxt;
          kind_r   <= kind_nxt;
          second_r <= second_nxt;
          cnt_r    <= cnt_nxt;
          nd_r     <= nd_nxt;
          neg_r    <= neg_nxt;
          len_r    <= len_r + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_nl && !ovf) begin
      ip_r   <= ip_nxt;
      fr_r   <= fr_nxt;
      fn_r   <= fn_nxt;
      x_r    <= x_nxt;
      uv_r   <= uv_nxt;
      px_r   <= px_nxt;
    end
  end
endmodule

### src/atfp_back.sv
`timescale 1ns / 1ps
module atfp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  atfp_pkg::job_t      q_head,
  output logic                q_pop,
  input  atfp_pkg::pwr_t      pt_wr,
  output logic                list_done,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic signed [31:0]  out_coord_x,
  output logic signed [31:0]  out_coord_y,
  output logic [15:0]         out_point_x,
  output logic [15:0]         out_point_y,
  output logic [4:0]          out_point_index,
  output logic [4:0]          out_point_count,
  output logic                out_last
);
  import atfp_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_DIV, B_POUT, B_LRD, B_LOUT} bst_t;

  bst_t              st_r;
  job_t              job_r;
  logic              sel_y_r;
  logic [FR_W-1:0]   rem_r, pw_r;
  logic [QW-1:0]     lo_r, q_r;
  logic [DC_W-1:0]   dc_r;
  logic [ADDR_W-1:0] k_r;
  logic              valid_r, last_r, done_r;
  logic [1:0]        kind_r;
  logic [31:0]       cx_r, cy_r;
  logic [15:0]       px_r, py_r;
  logic [PT_W-1:0]   idx_r, cntp_r;
  logic [31:0]       mem [MAX_POINTS];

  num_t            ld_num, cur_num;
  logic [FR_W-1:0] ld_pw;
  logic [NW-1:0]   ld_n;
  logic [FR_W:0]   rem_sh;
  logic            ge;
  logic [QW-1:0]   q_fin;
  logic [MW-1:0]   mag;
  logic [31:0]     coord;
  logic            out_take, k_last;

  always_ff @(posedge clk) begin
    if (pt_wr.en) mem[pt_wr.addr] <= pt_wr.data;
  end

  assign ld_num  = (st_r == B_IDLE) ? q_head.x : job_r.y;
  assign ld_pw   = pow10(ld_num.fn);
  assign ld_n    = (NW'(ld_num.fr) << FRAC_BITS) + NW'(ld_pw >> 1);
  assign rem_sh  = {rem_r, lo_r[QW-1]};
  assign ge      = (rem_sh >= {1'b0, pw_r});
  assign q_fin   = QW'({q_r, ge});
  assign cur_num = sel_y_r ? job_r.y : job_r.x;
  assign mag     = (MW'(cur_num.ip) << FRAC_BITS) + MW'(q_fin);
  assign q_pop   = (st_r == B_IDLE) && !q_empty;
  assign out_take = valid_r && !out_stall;
  assign k_last  = (CNT_W'(k_r) + CNT_W'(1) == job_r.count);

  always_comb begin
    // saturate to the signed 32-bit range
    if (cur_num.neg) coord = (mag >= MW'(32'h8000_0000)) ? 32'h8000_0000
                                                        : 32'd0 - mag[31:0];
    else coord = (mag > MW'(32'h7fff_ffff)) ? 32'h7fff_ffff : mag[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= B_IDLE;
      valid_r <= 1'b0;
      done_r  <= 1'b0;
      sel_y_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        B_IDLE: begin
          if (!q_empty) begin
            job_r <= q_head;
            k_r   <= '0;
            if (q_head.kind == KIND_LIST) begin
              st_r <= B_LRD;
            end else begin
              sel_y_r <= 1'b0;
              rem_r   <= ld_n[NW-1:QW];
              lo_r    <= ld_n[QW-1:0];
              pw_r    <= ld_pw;
              q_r     <= '0;
              dc_r    <= DC_W'(QW - 1);
              st_r    <= B_DIV;
            end
          end
        end
        B_DIV: begin
          rem_r <= ge ? FR_W'(rem_sh - {1'b0, pw_r}) : rem_sh[FR_W-1:0];
          lo_r  <= lo_r << 1;
          q_r   <= q_fin;
          dc_r  <= dc_r - DC_W'(1);
          if (dc_r == '0) begin
            if (!sel_y_r) begin
              cx_r    <= coord;
              sel_y_r <= 1'b1;
              rem_r   <= ld_n[NW-1:QW];
              lo_r    <= ld_n[QW-1:0];
              pw_r    <= ld_pw;
              q_r     <= '0;
              dc_r    <= DC_W'(QW - 1);
            end else begin
              cy_r    <= coord;
              kind_r  <= job_r.kind;
              px_r    <= '0;
              py_r    <= '0;
              idx_r   <= '0;
              cntp_r  <= '0;
              last_r  <= 1'b1;
              valid_r <= 1'b1;
              st_r    <= B_POUT;
            end
          end
        end
        B_POUT: begin
          if (out_take) begin
            valid_r <= 1'b0;
            st_r    <= B_IDLE;
          end
        end
        B_LRD: begin
          {py_r, px_r} <= mem[k_r];
          kind_r  <= KIND_LIST;
          cx_r    <= '0;
          cy_r    <= '0;
          idx_r   <= PT_W'(k_r);
          cntp_r  <= PT_W'(job_r.count);
          last_r  <= k_last;
          valid_r <= 1'b1;
          st_r    <= B_LOUT;
        end
        B_LOUT: begin
          if (out_take) begin
            valid_r <= 1'b0;
            if (last_r) begin
              done_r <= 1'b1;
              st_r   <= B_IDLE;
            end else begin
              k_r  <= k_r + ADDR_W'(1);
              st_r <= B_LRD;
            end
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assign list_done       = done_r;
  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_coord_x     = cx_r;
  assign out_coord_y     = cy_r;
  assign out_point_x     = px_r;
  assign out_point_y     = py_r;
  assign out_point_index = idx_r;
  assign out_point_count = cntp_r;
  assign out_last        = last_r;

`ifndef NO_ASSERTIONS
  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (st_r == B_POUT || st_r == B_LOUT))
    else $error("result valid outside an output state");
  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r != KIND_LIST) |-> last_r)
    else $error("pair result without last");
  a_list_index: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r == KIND_LIST) |-> (idx_r < cntp_r))
    else $error("point index beyond count");
`endif
endmodule

### src/ascii_target_frame_parser_unit.sv
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_stall   | in_rx_byte
// out_    | output    | out_valid / out_stall | kind, coord_x/y, point_x/y/index/count, last
// cfg_    | input     | cfg_we                | cfg_wdata (kind_enable)
//
// The front parser takes in text bytes; a newline queues the frame's job.
// For a pair, the shared restoring divider rounds x then y one quotient bit a cycle.
// A list emits one point at a time, each read from the registered point store and
// taken at the output before the next is read. rst_n is synchronous, active low;
// kind_enable resets to 7. List bytes stall while the previous list is still read out.
module ascii_target_frame_parser_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic signed [31:0] out_coord_x,
  output logic signed [31:0] out_coord_y,
  output logic [15:0]        out_point_x,
  output logic [15:0]        out_point_y,
  output logic [4:0]         out_point_index,
  output logic [4:0]         out_point_count,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_wdata
);
  import atfp_pkg::*;

  logic [2:0] kind_enable_r;
  logic       q_full, q_push, q_pop, q_empty, list_done;
  job_t       q_job, q_head;
  pwr_t       pt_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) kind_enable_r <= 3'd7;
    else if (cfg_we) kind_enable_r <= cfg_wdata;
  end

  atfp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_rx_byte(in_rx_byte), .kind_enable(kind_enable_r), .q_full(q_full),
    .q_push(q_push), .q_job(q_job), .pt_wr(pt_wr), .list_done(list_done)
  );

  atfp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_job(q_job), .full(q_full),
    .pop(q_pop), .head_job(q_head), .empty(q_empty)
  );

  atfp_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .pt_wr(pt_wr), .list_done(list_done), .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_coord_x(out_coord_x), .out_coord_y(out_coord_y),
    .out_point_x(out_point_x), .out_point_y(out_point_y),
    .out_point_index(out_point_index), .out_point_count(out_point_count),
    .out_last(out_last)
  );
endmodule
